>>> hw/rtl/lbtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lbtg_pkg;
    localparam int SLOTS_DEF = 16;
    localparam logic [31:0] LEASE_RST = 32'd1000000000;
    localparam logic [31:0] RATIO_RST = 32'd65536;
    localparam logic [62:0] MASK63 = {63{1'b1}};

    typedef enum logic [2:0] {
        CMD_INTENT = 3'd0,
        CMD_PAUSE  = 3'd1,
        CMD_RESUME = 3'd2,
        CMD_SPEED  = 3'd3,
        CMD_RESET  = 3'd4,
        CMD_GRANT  = 3'd5
    } t_cmd;

    localparam logic [1:0] REG_LEASE = 2'd0;
    localparam logic [1:0] REG_SIM   = 2'd1;
    localparam logic [1:0] REG_RATIO = 2'd2;

    localparam logic [1:0] ACT_ACTIVE  = 2'd1;
    localparam logic [1:0] ACT_LEAVING = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture item, do intent or control work
        logic clr;      // clear scan accumulators
        logic scan;     // visit one slot
        logic mul_lo;   // low partial product
        logic mul_hi;   // high partial product
        logic fin;      // finish grant
        logic emit;     // drive result strobe
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_grant;
        logic scan_last;
    } t_sts;
endpackage
`default_nettype wire

>>> hw/rtl/lbtg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lbtg_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    output logic              o_busy,
    input  lbtg_pkg::t_sts    i_sts,
    output lbtg_pkg::t_ctl    o_ctl
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_SCAN = 6'b000100,
        S_MLO  = 6'b001000,
        S_MHI  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_LOAD;
            S_LOAD: n_state = i_sts.is_grant ? S_SCAN : S_IDLE;
            S_SCAN: if (i_sts.scan_last) n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // commands
    always_comb begin
        o_busy       = (r_state != S_IDLE);
        o_ctl        = '0;
        o_ctl.load   = (r_state == S_IDLE) && i_start;
        o_ctl.clr    = (r_state == S_LOAD);
        o_ctl.emit   = ((r_state == S_LOAD) && !i_sts.is_grant) || (r_state == S_FIN);
        o_ctl.scan   = (r_state == S_SCAN);
        o_ctl.mul_lo = (r_state == S_MLO);
        o_ctl.mul_hi = (r_state == S_MHI);
        o_ctl.fin    = (r_state == S_FIN);
    end

    // a result only leaves from load or finish
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.emit |-> (r_state == S_LOAD || r_state == S_FIN))
        else $error("emit from wrong state");
    // scan is always followed by multiply when it ends
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_last) |=> r_state == S_MLO)
        else $error("scan exit broken");
    // no new item taken while busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> r_state == S_LOAD)
        else $error("load not followed");
endmodule
`default_nettype wire

>>> hw/rtl/lbtg_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lbtg_dp #(
    parameter int SLOTS = lbtg_pkg::SLOTS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  lbtg_pkg::t_ctl    i_ctl,
    output lbtg_pkg::t_sts    o_sts,
    input  wire               i_cfg_we,
    input  wire [1:0]         i_cfg_idx,
    input  wire [63:0]        i_cfg_data,
    input  wire [2:0]         i_command,
    input  wire [62:0]        i_now_ns,
    input  wire [3:0]         i_participant_index,
    input  wire [31:0]        i_epoch,
    input  wire [62:0]        i_time_value,
    input  wire [1:0]         i_participant_state,
    input  wire [31:0]        i_speed_ratio,
    output logic              o_done,
    output logic              o_accepted,
    output logic [62:0]       o_grant_time,
    output logic              o_is_paused,
    output logic              o_advanced,
    output logic [4:0]        o_active_count
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // configuration
    logic [31:0] r_lease, r_init_ratio;
    logic [62:0] r_init_sim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lease      <= lbtg_pkg::LEASE_RST;
            r_init_sim   <= '0;
            r_init_ratio <= lbtg_pkg::RATIO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lbtg_pkg::REG_LEASE: r_lease      <= i_cfg_data[31:0];
                lbtg_pkg::REG_SIM:   r_init_sim   <= i_cfg_data[62:0];
                lbtg_pkg::REG_RATIO: r_init_ratio <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // slot table
    logic [SLOTS-1:0] r_valid;
    logic [31:0] r_sepoch [SLOTS];
    logic [62:0] r_ssafe  [SLOTS];
    logic [1:0]  r_sact   [SLOTS];
    logic [63:0] r_sexp   [SLOTS];

    // time state and captured item
    logic [62:0] r_sim_now, r_sim_anchor, r_wall_anchor, r_now;
    logic [31:0] r_ratio, r_ctl_epoch;
    logic        r_pause, r_grant;
    logic [SW-1:0] r_ptr;
    logic [62:0] r_best;
    logic        r_found;
    logic [CW-1:0] r_count;
    logic [62:0] r_elapsed;
    logic [63:0] r_p_lo;
    logic [62:0] r_cap;
    logic        r_acc, r_adv;

    wire         idx_ok   = ({28'd0, i_participant_index} < 32'(SLOTS));
    wire [SW-1:0] widx    = SW'(i_participant_index);
    wire [31:0]  stored_ep = r_valid[widx] ? r_sepoch[widx] : 32'd0;
    wire         ctl_cmd  = (i_command >= 3'd1) && (i_command <= 3'd4);
    wire         ctl_ok   = i_epoch >= r_ctl_epoch;

    // current scan slot
    wire         s_v    = r_valid[r_ptr];
    wire         s_drop = s_v && (({1'b0, r_now} > r_sexp[r_ptr]) ||
                                  (r_sact[r_ptr] == lbtg_pkg::ACT_LEAVING));
    wire         s_act  = s_v && !s_drop && (r_sact[r_ptr] == lbtg_pkg::ACT_ACTIVE);

    // high partial product and cap sum
    wire [63:0] p_hi = {33'd0, r_elapsed[62:32]} * {32'd0, r_ratio};
    logic [63:0] scaled;
    logic [63:0] capsum;
    always_comb begin
        if (p_hi >= (64'd1 << 47)) scaled = {1'b0, lbtg_pkg::MASK63};
        else scaled = {p_hi[47:0], 16'd0} + {16'd0, r_p_lo[63:16]};
        if (scaled[63]) scaled = {1'b0, lbtg_pkg::MASK63};
        capsum = scaled + {1'b0, r_sim_anchor};
    end

    wire [62:0] best_c = (r_ratio != 32'd0 && r_cap < r_best) ? r_cap : r_best;

    assign o_sts.is_grant  = r_grant;
    assign o_sts.scan_last = (32'(r_ptr) == SLOTS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_sim_now     <= r_init_sim;
            r_sim_anchor  <= r_init_sim;
            r_wall_anchor <= '0;
            r_ratio       <= r_init_ratio;
            r_pause       <= 1'b0;
            r_ctl_epoch   <= '0;
            o_done        <= 1'b0;
        end else begin
            o_done <= i_ctl.emit;
            // item capture with intent and control work
            if (i_ctl.load) begin
                r_grant <= (i_command == lbtg_pkg::CMD_GRANT);
                r_now   <= i_now_ns;
                r_acc   <= 1'b0;
                r_adv   <= 1'b0;
                if (i_command == lbtg_pkg::CMD_INTENT) begin
                    if (idx_ok && i_epoch >= stored_ep) begin
                        r_valid[widx]  <= 1'b1;
                        r_sepoch[widx] <= i_epoch;
                        r_ssafe[widx]  <= i_time_value;
                        r_sact[widx]   <= i_participant_state;
                        r_sexp[widx]   <= {1'b0, i_now_ns} + {32'd0, r_lease};
                        r_acc          <= 1'b1;
                    end
                end else if (ctl_cmd && ctl_ok) begin
                    r_ctl_epoch <= i_epoch;
                    r_acc       <= 1'b1;
                    case (i_command)
                        lbtg_pkg::CMD_PAUSE:  r_pause <= 1'b1;
                        lbtg_pkg::CMD_RESUME: r_pause <= 1'b0;
                        lbtg_pkg::CMD_SPEED: begin
                            r_sim_anchor  <= r_sim_now;
                            r_wall_anchor <= i_now_ns;
                            r_ratio       <= i_speed_ratio;
                        end
                        default: begin
                            r_sim_anchor  <= i_time_value;
                            r_wall_anchor <= i_now_ns;
                            r_sim_now     <= i_time_value;
                            r_valid       <= '0;
                        end
                    endcase
                end
            end
            // scan setup
            if (i_ctl.clr) begin
                r_ptr     <= '0;
                r_best    <= lbtg_pkg::MASK63;
                r_found   <= 1'b0;
                r_count   <= '0;
                r_elapsed <= (r_now > r_wall_anchor) ? r_now - r_wall_anchor : 63'd0;
            end
            // one slot per cycle: expiry drop and minimum
            if (i_ctl.scan) begin
                r_ptr <= r_ptr + SW'(1);
                if (s_drop) r_valid[r_ptr] <= 1'b0;
                if (s_act && !r_pause) begin
                    r_found <= 1'b1;
                    r_count <= r_count + CW'(1);
                    if (!r_found || r_ssafe[r_ptr] < r_best) r_best <= r_ssafe[r_ptr];
                end
            end
            if (i_ctl.mul_lo)
                r_p_lo <= {32'd0, r_elapsed[31:0]} * {32'd0, r_ratio};
            if (i_ctl.mul_hi)
                r_cap <= capsum[63] ? lbtg_pkg::MASK63 : capsum[62:0];
            // advance only forward
            if (i_ctl.fin && r_found && best_c > r_sim_now) begin
                r_sim_now <= best_c;
                r_adv     <= 1'b1;
            end
        end
    end

    always_comb begin
        o_accepted     = r_acc;
        o_grant_time   = r_sim_now;
        o_is_paused    = r_pause;
        o_advanced     = r_adv;
        o_active_count = r_grant ? 5'(r_count) : 5'd0;
    end

    // advance only on grant and moves forward
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fin && r_found && best_c > r_sim_now) |=> r_adv && r_grant)
        else $error("advance outside grant");
    // grants never accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_grant) |-> !o_accepted)
        else $error("grant accepted");
    // paused grant counts nothing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_paused && r_grant) |-> (o_active_count == 5'd0))
        else $error("paused count");
endmodule
`default_nettype wire

>>> hw/rtl/lease_based_time_grant_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   signals                                   direction
// command   start, busy, i_command..i_speed_ratio          in
// result    o_done, o_accepted..o_active_count        out
// config    i_cfg_valid, o_cfg_ready, i_cfg_index/data in
//
// intent and control items go from start through the load state to the result strobe
// a grant goes from load through the expiry and minimum scan, one slot per
// cycle, then the low and high halves of the split speed-cap multiply and finish
// reset is synchronous; the table is cleared through its valid bits at once
// the result strobe lasts one cycle; the receiver cannot stall it
module lease_based_time_grant_arbiter #(
    parameter int SLOTS = lbtg_pkg::SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [2:0]   i_command,
    input  wire [62:0]  i_now_ns,
    input  wire [3:0]   i_participant_index,
    input  wire [31:0]  i_epoch,
    input  wire [62:0]  i_time_value,
    input  wire [1:0]   i_participant_state,
    input  wire [31:0]  i_speed_ratio,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [1:0]   i_cfg_index,
    input  wire [63:0]  i_cfg_data,
    output logic        o_done,
    output logic        o_accepted,
    output logic [62:0] o_grant_time,
    output logic        o_is_paused,
    output logic        o_advanced,
    output logic [4:0]  o_active_count
);
    lbtg_pkg::t_ctl ctl;
    lbtg_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    lbtg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_sts(sts), .o_ctl(ctl)
    );

    lbtg_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_idx(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_command(i_command), .i_now_ns(i_now_ns),
        .i_participant_index(i_participant_index), .i_epoch(i_epoch),
        .i_time_value(i_time_value), .i_participant_state(i_participant_state),
        .i_speed_ratio(i_speed_ratio),
        .o_done(o_done), .o_accepted(o_accepted), .o_grant_time(o_grant_time),
        .o_is_paused(o_is_paused), .o_advanced(o_advanced),
        .o_active_count(o_active_count)
    );
endmodule
`default_nettype wire
